// ===== rtl/dks_pkg.sv =====
// shared types, constants and sine coefficients for the dirichlet kernel sample generator
package dks_pkg;

  localparam int STEP_FRAC_BITS = 16;
  localparam int OUT_FRAC_BITS  = 16;
  localparam int INDEX_BITS     = 16;

  localparam int ORDER_W   = 16;
  localparam int STEP_W    = 32;
  localparam int COUNT_W   = 17;
  localparam int KV_W      = 18;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;

  // phase of x in units of pi, modulo 2
  localparam int PH_W    = STEP_FRAC_BITS + 1;
  // sine magnitude in q30, up to and including 1.0
  localparam int MAG_W   = 31;
  localparam int DEN_W   = ORDER_W + MAG_W;
  localparam int NUM_W   = MAG_W + OUT_FRAC_BITS;
  // quotient bits, one above 1.0 to catch overflow
  localparam int QUOT_W  = OUT_FRAC_BITS + 2;
  localparam int SIN_LAT = 8;

  localparam int Q_DEPTH_DEF   = 8;
  localparam int OUT_DEPTH_DEF = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KERNEL_ORDER = 2'd0,
    REG_STEP_FIXED   = 2'd1,
    REG_SAMPLE_COUNT = 2'd2
  } cfg_reg_t;

  // odd taylor terms of sin(pi u) in q28
  localparam logic [31:0] SIN_COEF [6] = '{
    32'd843314857, 32'd1387197337, 32'd684554447,
    32'd160863847, 32'd22050869,   32'd1978485
  };

  typedef struct packed {
    logic oor;
    logic last;
    logic whole;
    logic wneg;
  } side_t;

  typedef struct packed {
    side_t             side;
    logic [PH_W-1:0]   pb;
    logic [PH_W-1:0]   pt;
  } item_t;

  typedef struct packed {
    logic [KV_W-1:0] kernel_value;
    logic            last;
    logic            oor;
  } res_t;

endpackage

// ===== rtl/dks_fifo.sv =====
// small register fifo used for the classify queue and the result buffer
module dks_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [WIDTH-1:0]           wr_data,
  input  logic                       rd_en,
  output logic [WIDTH-1:0]           rd_data,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  assign rd_data = mem_r[rd_ptr_r];
  assign count   = count_r;

endmodule

// ===== rtl/dks_front.sv =====
// front end: range check, x and phase products, whole-x classification
module dks_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_vld,
  input  logic [dks_pkg::INDEX_BITS-1:0]    in_index,
  input  logic [dks_pkg::ORDER_W-1:0]       kernel_order,
  input  logic [dks_pkg::STEP_W-1:0]        step_fixed,
  input  logic [dks_pkg::COUNT_W-1:0]       sample_count,
  output logic                              out_vld,
  output dks_pkg::item_t                    out_item
);

  localparam int PH_W = dks_pkg::PH_W;
  localparam int XP_W = dks_pkg::INDEX_BITS + PH_W;
  localparam int TP_W = dks_pkg::ORDER_W + PH_W;
  localparam int SFB  = dks_pkg::STEP_FRAC_BITS;

  logic            v1_r, v2_r;
  logic            oor1_r, last1_r;
  logic [PH_W-1:0] x1_r, x1_nxt;
  logic            oor_nxt, last_nxt;
  logic [XP_W-1:0] xprod;
  logic [TP_W-1:0] tprod;
  dks_pkg::item_t  item_r, item_nxt;

  // only x mod 2 matters, so only the low phase bits of the product are kept
  assign xprod    = XP_W'(in_index) * XP_W'(step_fixed[PH_W-1:0]);
  assign x1_nxt   = xprod[PH_W-1:0];
  assign oor_nxt  = dks_pkg::COUNT_W'(in_index) >= sample_count;
  assign last_nxt = (dks_pkg::COUNT_W'(in_index) + dks_pkg::COUNT_W'(1)) == sample_count;

  assign tprod = TP_W'(kernel_order) * TP_W'(x1_r);

  always_comb begin
    item_nxt.side.oor   = oor1_r;
    item_nxt.side.last  = last1_r & ~oor1_r;
    item_nxt.side.whole = (x1_r[SFB-1:0] == '0);
    // n-1 odd means n even
    item_nxt.side.wneg  = x1_r[SFB] & ~kernel_order[0];
    item_nxt.pb         = x1_r;
    item_nxt.pt         = tprod[PH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    oor1_r  <= oor_nxt;
    last1_r <= last_nxt;
    x1_r    <= x1_nxt;
    item_r  <= item_nxt;
  end

  assign out_vld  = v2_r;
  assign out_item = item_r;

endmodule

// ===== rtl/dks_sine.sv =====
// pipelined |sin(pi p)| by quarter-wave folding and a degree 11 horner chain
module dks_sine (
  input  logic                        clk,
  input  logic [dks_pkg::PH_W-1:0]    phase,
  output logic [dks_pkg::MAG_W-1:0]   mag,
  output logic                        neg
);

  localparam int SFB   = dks_pkg::STEP_FRAC_BITS;
  localparam int MAG_W = dks_pkg::MAG_W;
  localparam int LAT   = dks_pkg::SIN_LAT;
  localparam logic [31:0] SIN_COEF_TOP = dks_pkg::SIN_COEF[5];

  logic [31:0]      r, u_nxt;
  logic [31:0]      u_r [7];
  logic [31:0]      s_r [5];
  logic [31:0]      t_r [5];
  logic             neg_r [LAT];
  logic [63:0]      uu, vprod;
  logic [MAG_W-1:0] mag_r, mag_nxt;

  assign r     = 32'(phase[SFB-1:0]) << (32 - SFB);
  assign u_nxt = (r <= 32'h8000_0000) ? r : 32'(33'h1_0000_0000 - 33'(r));
  assign uu    = 64'(u_r[0]) * 64'(u_r[0]);

  always_ff @(posedge clk) begin
    u_r[0]   <= u_nxt;
    neg_r[0] <= phase[SFB];
    s_r[0]   <= uu[63:32];
    u_r[1]   <= u_r[0];
  end

  for (genvar i = 1; i < LAT; i++) begin : g_neg
    always_ff @(posedge clk) begin
      neg_r[i] <= neg_r[i-1];
    end
  end

  for (genvar h = 0; h < 5; h++) begin : g_horner
    logic [31:0] t_in;
    logic [63:0] st;
    if (h == 0) begin : g_first
      assign t_in = SIN_COEF_TOP;
    end else begin : g_rest
      assign t_in = t_r[h-1];
    end
    assign st = 64'(s_r[h]) * 64'(t_in);
    always_ff @(posedge clk) begin
      t_r[h]   <= dks_pkg::SIN_COEF[4-h] - st[63:32];
      u_r[h+2] <= u_r[h+1];
    end
    if (h < 4) begin : g_carry
      always_ff @(posedge clk) begin
        s_r[h+1] <= s_r[h];
      end
    end
  end

  assign vprod   = 64'(u_r[6]) * 64'(t_r[4]);
  assign mag_nxt = (vprod[63:30] > 34'h4000_0000) ? MAG_W'(32'h4000_0000)
                                                  : MAG_W'(vprod[63:30]);

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
  end

  assign mag = mag_r;
  assign neg = neg_r[LAT-1];

endmodule

// ===== rtl/dks_back.sv =====
// back end: two sines, divisor product, restoring divide and result assembly
module dks_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [dks_pkg::ORDER_W-1:0]   kernel_order,
  input  logic                          in_vld,
  input  dks_pkg::item_t                in_item,
  output logic                          res_vld,
  output dks_pkg::res_t                 res
);

  localparam int LAT    = dks_pkg::SIN_LAT;
  localparam int QW     = dks_pkg::QUOT_W;
  localparam int NUM_W  = dks_pkg::NUM_W;
  localparam int DEN_W  = dks_pkg::DEN_W;
  localparam int SH_W   = DEN_W + QW;
  localparam int OFB    = dks_pkg::OUT_FRAC_BITS;
  localparam int KV_W   = dks_pkg::KV_W;

  logic [dks_pkg::MAG_W-1:0] tm, bm;
  logic                      nt, nb;
  logic                      sv_r [LAT];
  dks_pkg::side_t            ss_r [LAT];

  // stage 0 forms the divisor, stages 1..QW each settle one quotient bit
  logic                 qv_r   [QW+1];
  dks_pkg::side_t       qside_r[QW+1];
  logic [NUM_W-1:0]     qrem_r [QW+1];
  logic [DEN_W-1:0]     qden_r [QW+1];
  logic [QW-1:0]        qq_r   [QW+1];
  logic                 qneg_r [QW+1];

  logic                 res_vld_r;
  dks_pkg::res_t        res_r, res_nxt;
  logic [QW-1:0]        mag;
  logic [63:0]          m64;

  dks_sine u_sine_top (.clk(clk), .phase(in_item.pt), .mag(tm), .neg(nt));
  dks_sine u_sine_bot (.clk(clk), .phase(in_item.pb), .mag(bm), .neg(nb));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r[0] <= 1'b0;
    end else begin
      sv_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    ss_r[0] <= in_item.side;
  end

  for (genvar i = 1; i < LAT; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[i] <= 1'b0;
      end else begin
        sv_r[i] <= sv_r[i-1];
      end
    end
    always_ff @(posedge clk) begin
      ss_r[i] <= ss_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qv_r[0] <= 1'b0;
    end else begin
      qv_r[0] <= sv_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    qside_r[0] <= ss_r[LAT-1];
    qrem_r[0]  <= NUM_W'(tm) << OFB;
    qden_r[0]  <= DEN_W'(kernel_order) * DEN_W'(bm);
    qq_r[0]    <= '0;
    qneg_r[0]  <= ss_r[LAT-1].whole ? ss_r[LAT-1].wneg : (nt ^ nb);
  end

  for (genvar j = 1; j <= QW; j++) begin : g_div
    localparam int B = QW - j;
    logic [SH_W-1:0] dsh;
    logic            ge;
    assign dsh = SH_W'(qden_r[j-1]) << B;
    assign ge  = SH_W'(qrem_r[j-1]) >= dsh;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        qv_r[j] <= 1'b0;
      end else begin
        qv_r[j] <= qv_r[j-1];
      end
    end
    always_ff @(posedge clk) begin
      qside_r[j] <= qside_r[j-1];
      qden_r[j]  <= qden_r[j-1];
      qneg_r[j]  <= qneg_r[j-1];
      qrem_r[j]  <= ge ? NUM_W'(SH_W'(qrem_r[j-1]) - dsh) : qrem_r[j-1];
      qq_r[j]    <= qq_r[j-1] | (QW'(ge) << B);
    end
  end

  // zero divisor sets every bit, which clamps to 1.0 below
  always_comb begin
    if (qside_r[QW].whole || (qq_r[QW] > (QW'(1) << OFB))) begin
      mag = QW'(1) << OFB;
    end else begin
      mag = qq_r[QW];
    end
    m64 = 64'(mag);
    res_nxt.oor  = qside_r[QW].oor;
    res_nxt.last = qside_r[QW].last;
    if (qside_r[QW].oor) begin
      res_nxt.kernel_value = '0;
    end else begin
      res_nxt.kernel_value = KV_W'(qneg_r[QW] ? (64'd0 - m64) : m64);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else begin
      res_vld_r <= qv_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res_vld = res_vld_r;
  assign res     = res_r;

endmodule

// ===== rtl/dirichlet_kernel_sample_generator.sv =====
// top level of the dirichlet kernel sample generator
//
// usage:
//   input channel: in_sample_index with in_valid / in_stall; a transfer takes
//   place on a rising edge with in_valid high and in_stall low.
//   result channel: out_kernel_value (signed, 16 fraction bits), out_last_sample
//   and out_out_of_range with out_valid / out_stall, one result per transfer in.
//   config: write kernel_order (0), step_fixed (1), sample_count (2) through
//   cfg_we / cfg_index / cfg_data, only while no item is in flight.
// throughput: one item per clock while in_stall is low; the sine, divisor and
//   divide units are fully pipelined; every stage takes a new item each cycle.
// path: an input item passes 2 front stages, the queue, 8 sine stages, the
//   divisor stage, 18 divide stages, the result stage and the result buffer
//   before out_valid rises.
// reset: config registers return to N=1, step=4096, count=1024; queues empty.
// receiver stall: results collect in a 32-entry buffer; one credit counter
//   holds queue pops once buffer space is all spoken for, another raises
//   in_stall once queue space is, so no result is dropped.
module dirichlet_kernel_sample_generator #(
  parameter int Q_DEPTH   = dks_pkg::Q_DEPTH_DEF,
  parameter int OUT_DEPTH = dks_pkg::OUT_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [dks_pkg::INDEX_BITS-1:0]  in_sample_index,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [dks_pkg::KV_W-1:0] out_kernel_value,
  output logic                            out_last_sample,
  output logic                            out_out_of_range,
  input  logic                            cfg_we,
  input  logic [dks_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dks_pkg::CFG_W-1:0]       cfg_data
);

  localparam int QC_W = $clog2(Q_DEPTH+1);
  localparam int OC_W = $clog2(OUT_DEPTH+1);
  localparam int IT_W = $bits(dks_pkg::item_t);
  localparam int RS_W = $bits(dks_pkg::res_t);

  // configuration registers
  logic [dks_pkg::ORDER_W-1:0] order_r;
  logic [dks_pkg::STEP_W-1:0]  step_r;
  logic [dks_pkg::COUNT_W-1:0] count_r;

  logic           in_xfer, out_xfer;
  logic           f_vld, q_pop, b_vld;
  dks_pkg::item_t f_item, q_item, b_item;
  dks_pkg::res_t  res, o_res;
  logic [IT_W-1:0] q_rd;
  logic [RS_W-1:0] o_rd;
  logic [QC_W-1:0] q_count;
  logic [OC_W-1:0] o_count;

  // credits: items accepted but not yet popped from the queue, and items
  // popped but not yet transferred out
  logic [QC_W-1:0] fres_r, fres_nxt;
  logic [OC_W-1:0] bres_r, bres_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= dks_pkg::ORDER_W'(1);
      step_r  <= dks_pkg::STEP_W'(4096);
      count_r <= dks_pkg::COUNT_W'(1024);
    end else if (cfg_we) begin
      case (dks_pkg::cfg_reg_t'(cfg_index))
        dks_pkg::REG_KERNEL_ORDER: order_r <= cfg_data[dks_pkg::ORDER_W-1:0];
        dks_pkg::REG_STEP_FIXED:   step_r  <= cfg_data[dks_pkg::STEP_W-1:0];
        dks_pkg::REG_SAMPLE_COUNT: count_r <= cfg_data[dks_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall = (fres_r >= QC_W'(Q_DEPTH));
  assign in_xfer  = in_valid && !in_stall;
  assign q_pop    = (q_count != '0) && (bres_r < OC_W'(OUT_DEPTH));
  assign out_valid = (o_count != '0);
  assign out_xfer  = out_valid && !out_stall;

  always_comb begin
    fres_nxt = fres_r + QC_W'(in_xfer) - QC_W'(q_pop);
    bres_nxt = bres_r + OC_W'(q_pop) - OC_W'(out_xfer);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fres_r <= '0;
      bres_r <= '0;
    end else begin
      fres_r <= fres_nxt;
      bres_r <= bres_nxt;
    end
  end

  dks_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_vld       (in_xfer),
    .in_index     (in_sample_index),
    .kernel_order (order_r),
    .step_fixed   (step_r),
    .sample_count (count_r),
    .out_vld      (f_vld),
    .out_item     (f_item)
  );

  // classify queue between front and back
  dks_fifo #(.WIDTH(IT_W), .DEPTH(Q_DEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (f_vld),
    .wr_data (f_item),
    .rd_en   (q_pop),
    .rd_data (q_rd),
    .count   (q_count)
  );

  assign q_item = dks_pkg::item_t'(q_rd);
  assign b_item = q_item;

  dks_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .kernel_order (order_r),
    .in_vld       (q_pop),
    .in_item      (b_item),
    .res_vld      (b_vld),
    .res          (res)
  );

  // result buffer absorbs everything the back end has in flight
  dks_fifo #(.WIDTH(RS_W), .DEPTH(OUT_DEPTH)) u_outbuf (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (b_vld),
    .wr_data (res),
    .rd_en   (out_xfer),
    .rd_data (o_rd),
    .count   (o_count)
  );

  assign o_res            = dks_pkg::res_t'(o_rd);
  assign out_kernel_value = o_res.kernel_value;
  assign out_last_sample  = o_res.last;
  assign out_out_of_range = o_res.oor;

  // credit never exceeds the queue it guards
  a_fres_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fres_r <= QC_W'(Q_DEPTH))
    else $error("front credit overrun");

  // a result arriving always finds room in the buffer
  a_outbuf_room: assert property (@(posedge clk) disable iff (!rst_n)
    b_vld |-> (o_count < OC_W'(OUT_DEPTH)))
    else $error("result buffer overflow");

  // a front item never lands on a full queue
  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    f_vld |-> (q_count < QC_W'(Q_DEPTH)))
    else $error("queue overflow");

  // buffered results are always covered by back credit
  a_bres_cover: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (bres_r >= OC_W'(o_count)))
    else $error("back credit lost");

endmodule

// ===== test/testbench.sv =====
// testbench for the dirichlet kernel sample generator: directed and random index streams
`timescale 1ns / 100ps
module testbench;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [dks_pkg::INDEX_BITS-1:0]  in_sample_index = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic signed [dks_pkg::KV_W-1:0] out_kernel_value;
  logic                            out_last_sample;
  logic                            out_out_of_range;
  logic                            cfg_we = 1'b0;
  logic [dks_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [dks_pkg::CFG_W-1:0]       cfg_data = '0;

  dirichlet_kernel_sample_generator u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_sample_index(in_sample_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_kernel_value(out_kernel_value), .out_last_sample(out_last_sample),
    .out_out_of_range(out_out_of_range),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // shadow copy of the configuration registers
  logic [dks_pkg::ORDER_W-1:0] order_q = 16'd1;
  logic [dks_pkg::STEP_W-1:0]  step_q  = 32'd4096;
  logic [dks_pkg::COUNT_W-1:0] count_q = 17'd1024;

  dks_pkg::res_t sample_queue[$];
  int     errors = 0;
  int     hold_cycles = 0;   // long receiver hold-off, counted by the stall process
  bit     random_stall = 1'b1;

  // quarter-wave folded odd polynomial, |sin| in q30
  function automatic logic [63:0] sin_mag_q30(input logic [32:0] phase, output bit neg);
    logic [63:0] r, u, s, t, v;
    r = {32'd0, phase[31:0]};
    neg = phase[32];
    u = (r <= 64'h8000_0000) ? r : (64'h1_0000_0000 - r);
    s = (u * u) >> 32;
    t = 64'(dks_pkg::SIN_COEF[5]);
    t = 64'(dks_pkg::SIN_COEF[4]) - ((s * t) >> 32);
    t = 64'(dks_pkg::SIN_COEF[3]) - ((s * t) >> 32);
    t = 64'(dks_pkg::SIN_COEF[2]) - ((s * t) >> 32);
    t = 64'(dks_pkg::SIN_COEF[1]) - ((s * t) >> 32);
    t = 64'(dks_pkg::SIN_COEF[0]) - ((s * t) >> 32);
    v = (u * t) >> 30;
    return (v > 64'h4000_0000) ? 64'h4000_0000 : v;
  endfunction

  function automatic dks_pkg::res_t kernel_sample(input logic [dks_pkg::INDEX_BITS-1:0] idx);
    dks_pkg::res_t r;
    logic [63:0] x, one, mag, tm, bm, den, pb, pt;
    bit neg, nt, nb;
    one = 64'd1 << dks_pkg::OUT_FRAC_BITS;
    r = '0;
    if (17'(idx) >= count_q) begin
      r.oor = 1'b1;
      return r;
    end
    r.last = (17'(idx) + 17'd1 == count_q);
    x = 64'(idx) * 64'(step_q);
    if (x[dks_pkg::STEP_FRAC_BITS-1:0] == '0) begin
      neg = x[dks_pkg::STEP_FRAC_BITS] && (order_q - 16'd1) % 2 == 1;
      mag = one;
    end else begin
      pb = (x & ((64'd1 << dks_pkg::PH_W) - 1)) << (32 - dks_pkg::STEP_FRAC_BITS);
      pt = ((64'(order_q) * x) & ((64'd1 << dks_pkg::PH_W) - 1))
           << (32 - dks_pkg::STEP_FRAC_BITS);
      tm = sin_mag_q30(pt[32:0], nt);
      bm = sin_mag_q30(pb[32:0], nb);
      den = 64'(order_q) * bm;
      neg = nt != nb;
      if (den == 0) mag = one;
      else begin
        mag = (tm << dks_pkg::OUT_FRAC_BITS) / den;
        if (mag > one) mag = one;
      end
    end
    r.kernel_value = neg ? dks_pkg::KV_W'(-mag) : dks_pkg::KV_W'(mag);
    return r;
  endfunction

  // one index transfer, driven on falling edges; valid stays high afterwards
  task automatic send_index(input logic [dks_pkg::INDEX_BITS-1:0] idx);
    in_valid <= 1'b1;
    in_sample_index <= idx;
    do @(posedge clk); while (in_stall);
    sample_queue.push_back(kernel_sample(idx));
    @(negedge clk);
  endtask

  // burst sender: random gaps between bursts, valid kept high inside a burst
  task automatic send_burst(input int n, input int span);
    int k, gap;
    for (k = 0; k < n; k++) begin
      send_index((span >= 65536) ? dks_pkg::INDEX_BITS'($urandom) :
                 dks_pkg::INDEX_BITS'($urandom_range(span - 1, 0)));
    end
    gap = $urandom_range(6, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (sample_queue.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(input dks_pkg::cfg_reg_t which,
                           input logic [dks_pkg::CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= which;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (which)
      dks_pkg::REG_KERNEL_ORDER: order_q = val[dks_pkg::ORDER_W-1:0];
      dks_pkg::REG_STEP_FIXED:   step_q = val;
      default:                   count_q = val[dks_pkg::COUNT_W-1:0];
    endcase
    @(negedge clk);
  endtask

  task automatic test_reset_defaults;
    send_index(16'd0);
    send_index(16'd1);
    send_index(16'd16);
    send_index(16'd1023);
    send_index(16'd1024);
    send_index(16'hFFFF);
    drain();
  endtask

  task automatic test_directed_extremes;
    write_reg(dks_pkg::REG_KERNEL_ORDER, 32'd2);
    write_reg(dks_pkg::REG_STEP_FIXED, 32'h0001_0000);   // every x whole
    write_reg(dks_pkg::REG_SAMPLE_COUNT, 32'h1_0000);
    send_index(16'd0);
    send_index(16'd1);
    send_index(16'd2);
    send_index(16'hFFFF);
    drain();
    write_reg(dks_pkg::REG_KERNEL_ORDER, 32'd0);         // zero divisor
    write_reg(dks_pkg::REG_STEP_FIXED, 32'h0000_8000);
    send_index(16'd1);
    send_index(16'd3);
    drain();
    write_reg(dks_pkg::REG_KERNEL_ORDER, 32'hFFFF);
    write_reg(dks_pkg::REG_STEP_FIXED, 32'hFFFF_FFFF);
    send_index(16'd1);
    send_index(16'hAAAA);
    send_index(16'h5555);
    drain();
    write_reg(dks_pkg::REG_STEP_FIXED, 32'd0);           // zero step
    write_reg(dks_pkg::REG_SAMPLE_COUNT, 32'd0);         // nothing in range
    send_index(16'd0);
    send_index(16'd7);
    drain();
    write_reg(dks_pkg::REG_SAMPLE_COUNT, 32'd1);
    send_index(16'd0);
    send_index(16'd1);
    drain();
  endtask

  task automatic test_random_settings;
    int p, span;
    for (p = 0; p < 12; p++) begin
      write_reg(dks_pkg::REG_KERNEL_ORDER, (p % 4 == 0) ? 32'd1 : (p % 4 == 1) ? 32'hFFFF :
                $urandom_range(40, 1) | ($urandom_range(1, 0) ? $urandom : 0));
      write_reg(dks_pkg::REG_STEP_FIXED, (p == 3) ? 32'd1 : (p == 4) ? 32'hFFFF_FFFF :
                ($urandom_range(1, 0) ? $urandom_range(65536, 1) : $urandom));
      write_reg(dks_pkg::REG_SAMPLE_COUNT,
                (p == 5) ? 32'h1_0000 : $urandom_range(300, 1));
      span = (p % 3 == 0) ? 65536 : int'(count_q) + 8;
      repeat (6) send_burst($urandom_range(8, 1), span);
      drain();
    end
  endtask

  task automatic test_backpressure;
    int k;
    write_reg(dks_pkg::REG_KERNEL_ORDER, 32'd5);
    write_reg(dks_pkg::REG_STEP_FIXED, 32'd1234);
    write_reg(dks_pkg::REG_SAMPLE_COUNT, 32'd200);
    hold_cycles = 300;
    for (k = 0; k < 60; k++) send_burst(1, 210);
    drain();   // sender pauses until every result is in
  endtask

  // receiver stall pattern plus long hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (random_stall)
      out_stall <= ($urandom_range(9, 0) < 3);
    else
      out_stall <= 1'b0;
  end

  // result checker
  always @(posedge clk) begin
    dks_pkg::res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (sample_queue.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        e = sample_queue.pop_front();
        if (out_kernel_value !== e.kernel_value) begin
          $error("kernel_value expected %0h actual %0h", e.kernel_value, out_kernel_value);
          errors++;
        end
        if (out_last_sample !== e.last) begin
          $error("last_sample expected %0b actual %0b", e.last, out_last_sample);
          errors++;
        end
        if (out_out_of_range !== e.oor) begin
          $error("out_of_range expected %0b actual %0b", e.oor, out_out_of_range);
          errors++;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_defaults();
    test_directed_extremes();
    test_random_settings();
    test_backpressure();
    random_stall = 1'b0;
    test_random_settings();
    if (errors == 0 && sample_queue.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule
